>>> src/dnr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnr_pkg: shared types and constants of the detour noise recorder
// Field widths, register indexes and reset values used by the interfaces
// and the core.
// ----------------------------------------------------------------------------
package dnr_pkg;

	localparam int TS_W    = 64;   // timestamp and 64-bit statistics
	localparam int REC_W   = 16;   // record limit and recorded count
	localparam int IDX_W   = 17;   // signed detour index
	localparam int CFG_W   = 64;   // widest configuration register
	localparam int CFG_A_W = 2;    // configuration register index

	typedef enum logic [CFG_A_W-1:0] {
		REG_GAP_THRESHOLD = 2'd0,
		REG_TIMEOUT_TICKS = 2'd1,
		REG_RECORD_LIMIT  = 2'd2
	} reg_idx_t;

	localparam logic [TS_W-1:0]  GAP_THRESHOLD_RST = 64'd1000;
	localparam logic [TS_W-1:0]  TIMEOUT_TICKS_RST = 64'd4000000000;
	localparam logic [REC_W-1:0] RECORD_LIMIT_RST  = 16'd3000;
	localparam logic [TS_W-1:0]  GAP_MIN_RST       = 64'h0000_0000_8000_0000;

	// input command codes
	localparam logic CMD_BEGIN  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

endpackage

>>> src/dnr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnr_sample_if / dnr_result_if: item channels of the detour noise recorder
// Valid/ready channels carrying one sample item or one result item.
// ----------------------------------------------------------------------------
interface dnr_sample_if;
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [dnr_pkg::TS_W-1:0]  timestamp;

	modport source (output valid, output cmd, output timestamp, input ready);
	modport sink   (input valid, input cmd, input timestamp, output ready);
endinterface

interface dnr_result_if;
	logic                      valid;
	logic                      ready;
	logic                      has_detour;
	logic [dnr_pkg::TS_W-1:0]  detour_start;
	logic [dnr_pkg::TS_W-1:0]  detour_length;
	logic                      run_finished;
	logic [dnr_pkg::REC_W-1:0] recorded_total;
	logic [dnr_pkg::TS_W-1:0]  smallest_gap;
	logic [dnr_pkg::TS_W-1:0]  largest_gap;
	logic [dnr_pkg::TS_W-1:0]  samples_taken;
	logic [dnr_pkg::TS_W-1:0]  elapsed_ticks;

	modport source (output valid, output has_detour, output detour_start,
		output detour_length, output run_finished, output recorded_total,
		output smallest_gap, output largest_gap, output samples_taken,
		output elapsed_ticks, input ready);
	modport sink   (input valid, input has_detour, input detour_start,
		input detour_length, input run_finished, input recorded_total,
		input smallest_gap, input largest_gap, input samples_taken,
		input elapsed_ticks, output ready);
endinterface

>>> src/detour_noise_recorder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detour_noise_recorder_core: OS noise detour recorder
// Watches free-running timestamps, reports gaps above a threshold as
// detours and closes a run with min/max gap, sample count and elapsed time.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake      payload
//  -------   ---------  -------------  -------------------------------------
//  sample    in         valid/ready    cmd, timestamp
//  result    out        valid/ready    has_detour .. elapsed_ticks (9 fields)
//  wr_*      in         wr_en only     wr_index (2b), wr_data (64b)
//
//  One item per clock sustained while results are taken. An accepted item
//  sits in the input stage, where the gap subtract and the threshold/timeout
//  compares run against the run state, and its result (if any) is registered
//  in the result register once that register is empty or being drained.
//  Reset clears the run state and loads register defaults; the block is
//  idle and ignores samples until a begin item arrives.
//  A result not taken holds the input stage; items without a result still
//  pass through while the result register is empty or being drained.
//
module detour_noise_recorder_core #(
	parameter int WARMUP_DETOURS = 10   // detours only counted, 0..255
) (
	input  logic                          clk,
	input  logic                          arst_n,
	dnr_sample_if.sink                    sample,
	dnr_result_if.source                  result,
	input  logic                          wr_en,
	input  logic [dnr_pkg::CFG_A_W-1:0]   wr_index,
	input  logic [dnr_pkg::CFG_W-1:0]     wr_data
);

	localparam int TS_W  = dnr_pkg::TS_W;
	localparam int REC_W = dnr_pkg::REC_W;
	localparam int IDX_W = dnr_pkg::IDX_W;

	// detour index restarts at minus the warm-up count
	localparam logic signed [IDX_W-1:0] IDX_RST = -$signed(IDX_W'(WARMUP_DETOURS));

	// ---------------- configuration registers ----------------
	logic [TS_W-1:0]  gap_threshold_q;
	logic [TS_W-1:0]  timeout_ticks_q;
	logic [REC_W-1:0] record_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_threshold_q <= dnr_pkg::GAP_THRESHOLD_RST;
			timeout_ticks_q <= dnr_pkg::TIMEOUT_TICKS_RST;
			record_limit_q  <= dnr_pkg::RECORD_LIMIT_RST;
		end else if (wr_en) begin
			case (wr_index)
				dnr_pkg::REG_GAP_THRESHOLD: gap_threshold_q <= wr_data;
				dnr_pkg::REG_TIMEOUT_TICKS: timeout_ticks_q <= wr_data;
				dnr_pkg::REG_RECORD_LIMIT:  record_limit_q  <= wr_data[REC_W-1:0];
				default: ;  // unmapped index: write dropped
			endcase
		end
	end

	// ---------------- input stage ----------------
	logic            valid_s1;
	logic            cmd_s1;
	logic [TS_W-1:0] ts_s1;

	logic out_valid_q;
	logic can_adv;   // result register can take this cycle's outcome
	logic proc;      // input stage item is consumed this cycle

	assign can_adv      = !out_valid_q || result.ready;
	assign proc         = valid_s1 && can_adv;
	assign sample.ready = !valid_s1 || can_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			cmd_s1 <= sample.cmd;
			ts_s1  <= sample.timestamp;
		end
	end

	// ---------------- run state ----------------
	logic                    running_q;
	logic [TS_W-1:0]         prev_q;
	logic [TS_W-1:0]         win_start_q;
	logic signed [IDX_W-1:0] idx_q;
	logic [REC_W-1:0]        rec_cnt_q;
	logic [TS_W-1:0]         gap_max_q;
	logic [TS_W-1:0]         gap_min_q;
	logic [TS_W-1:0]         smp_cnt_q;
	logic [TS_W-1:0]         first_start_q;

	// ---------------- per-sample decision ----------------
	logic                    is_sample;
	logic [TS_W-1:0]         gap;
	logic                    over_thr;
	logic                    rec;         // detour past warm-up, gets reported
	logic                    first_rec;   // first reported detour of the run
	logic signed [IDX_W-1:0] idx_inc;
	logic                    lim_hit;
	logic [TS_W-1:0]         win_eff;
	logic [TS_W-1:0]         first_eff;
	logic [TS_W-1:0]         win_span;
	logic                    tmo_hit;
	logic                    fin;
	logic [REC_W-1:0]        rec_cnt_nxt;
	logic                    emit;

	assign is_sample   = (cmd_s1 == dnr_pkg::CMD_SAMPLE) && running_q;
	assign gap         = ts_s1 - prev_q;
	assign over_thr    = gap > gap_threshold_q;
	assign rec         = over_thr && !idx_q[IDX_W-1];
	assign first_rec   = rec && (idx_q == '0);
	assign idx_inc     = idx_q + IDX_W'(1);
	// limit check only once the index is non-negative
	assign lim_hit     = over_thr && !idx_inc[IDX_W-1]
		&& ($unsigned(idx_inc) >= {1'b0, record_limit_q});
	// first recorded detour restarts the timeout window at its start
	assign win_eff     = first_rec ? prev_q : win_start_q;
	assign first_eff   = first_rec ? prev_q : first_start_q;
	// window restarted at prev_q spans exactly the gap
	assign win_span    = first_rec ? gap : (ts_s1 - win_start_q);
	assign tmo_hit     = win_span >= timeout_ticks_q;
	assign fin         = lim_hit || tmo_hit;
	assign rec_cnt_nxt = rec_cnt_q + REC_W'(rec);
	assign emit        = is_sample && (fin || rec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q     <= 1'b0;
			prev_q        <= '0;
			win_start_q   <= '0;
			idx_q         <= IDX_RST;
			rec_cnt_q     <= '0;
			gap_max_q     <= '0;
			gap_min_q     <= dnr_pkg::GAP_MIN_RST;
			smp_cnt_q     <= '0;
			first_start_q <= '0;
		end else if (proc) begin
			if (cmd_s1 == dnr_pkg::CMD_BEGIN) begin
				// begin: clear stats and prime with this timestamp
				running_q     <= 1'b1;
				prev_q        <= ts_s1;
				win_start_q   <= ts_s1;
				idx_q         <= IDX_RST;
				rec_cnt_q     <= '0;
				gap_max_q     <= '0;
				gap_min_q     <= dnr_pkg::GAP_MIN_RST;
				smp_cnt_q     <= '0;
				first_start_q <= '0;
			end else if (running_q) begin
				if (over_thr)
					idx_q <= idx_inc;
				rec_cnt_q     <= rec_cnt_nxt;
				win_start_q   <= win_eff;
				first_start_q <= first_eff;
				if (fin) begin
					// ending sample leaves min/max/count untouched
					running_q <= 1'b0;
				end else begin
					prev_q    <= ts_s1;
					smp_cnt_q <= smp_cnt_q + TS_W'(1);
					if (gap > gap_max_q)
						gap_max_q <= gap;
					if (gap < gap_min_q)
						gap_min_q <= gap;
				end
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= emit;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic                has_detour_q;
	logic [TS_W-1:0]     detour_start_q;
	logic [TS_W-1:0]     detour_length_q;
	logic                run_finished_q;
	logic [REC_W-1:0]    recorded_total_q;
	logic [TS_W-1:0]     smallest_gap_q;
	logic [TS_W-1:0]     largest_gap_q;
	logic [TS_W-1:0]     samples_taken_q;
	logic [TS_W-1:0]     elapsed_ticks_q;

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			has_detour_q     <= rec;
			detour_start_q   <= rec ? prev_q : '0;
			detour_length_q  <= rec ? gap : '0;
			run_finished_q   <= fin;
			recorded_total_q <= rec_cnt_nxt;
			smallest_gap_q   <= fin ? gap_min_q : '0;
			largest_gap_q    <= fin ? gap_max_q : '0;
			samples_taken_q  <= fin ? smp_cnt_q : '0;
			// zero when nothing was recorded during the run
			elapsed_ticks_q  <= (fin && (rec_cnt_nxt != '0))
				? (first_rec ? gap : (ts_s1 - first_start_q)) : '0;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.has_detour     = has_detour_q;
	assign result.detour_start   = detour_start_q;
	assign result.detour_length  = detour_length_q;
	assign result.run_finished   = run_finished_q;
	assign result.recorded_total = recorded_total_q;
	assign result.smallest_gap   = smallest_gap_q;
	assign result.largest_gap    = largest_gap_q;
	assign result.samples_taken  = samples_taken_q;
	assign result.elapsed_ticks  = elapsed_ticks_q;

endmodule

>>> sim/detour_noise_recorder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detour_noise_recorder_core_tb: self-checking bench for the detour recorder
// Feeds begin/sample items built as timestamp runs with random gaps around
// the threshold, tracks run state alongside the core, and compares every
// result item field by field. Both channels idle at random; one phase holds
// the result side off long enough to back the core up.
// ----------------------------------------------------------------------------
module detour_noise_recorder_core_tb;

	localparam int TS_W    = dnr_pkg::TS_W;
	localparam int REC_W   = dnr_pkg::REC_W;
	localparam int CFG_W   = dnr_pkg::CFG_W;
	localparam int CFG_A_W = dnr_pkg::CFG_A_W;

	localparam int CLK_PERIOD     = 10;
	localparam int WARMUP         = 10;
	localparam int HOLD_CYCLES    = 200;   // long result-side hold-off
	localparam int DRAIN_CYCLES   = 6;     // input stage and result register plus margin
	localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
	localparam int N_PHASES       = 8;
	localparam int PHASE_ITEMS    = 232;

	typedef struct {
		logic            cmd;
		logic [TS_W-1:0] timestamp;
	} sample_item_t;

	typedef struct {
		logic             has_detour;
		logic [TS_W-1:0]  detour_start;
		logic [TS_W-1:0]  detour_length;
		logic             run_finished;
		logic [REC_W-1:0] recorded_total;
		logic [TS_W-1:0]  smallest_gap;
		logic [TS_W-1:0]  largest_gap;
		logic [TS_W-1:0]  samples_taken;
		logic [TS_W-1:0]  elapsed_ticks;
	} report_t;

	logic clk;
	logic arst_n;
	logic             wr_en;
	logic [CFG_A_W-1:0] wr_index;
	logic [CFG_W-1:0] wr_data;

	dnr_sample_if smp ();
	dnr_result_if res ();

	detour_noise_recorder_core #(
		.WARMUP_DETOURS(WARMUP)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (smp),
		.result  (res),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data)
	);

	// ---- bench state ------------------------------------------------------
	sample_item_t sample_backlog[$];   // items waiting for the driver
	report_t      expected_reports[$]; // predicted result items, oldest first

	// shadow copy of the config registers
	logic [TS_W-1:0]  thr_q;
	logic [TS_W-1:0]  tmo_q;
	logic [REC_W-1:0] lim_q;

	// shadow run state
	logic [TS_W-1:0]  prev_t;
	logic [TS_W-1:0]  win_t;
	int               detour_idx;
	logic [REC_W-1:0] rec_cnt;
	logic [TS_W-1:0]  gap_hi;
	logic [TS_W-1:0]  gap_lo;
	logic [TS_W-1:0]  sample_cnt;
	logic [TS_W-1:0]  first_rec_t;
	bit               running;

	// stimulus / handshake control
	bit  calm;        // last part of the run: no idling on either side
	bit  hold_go;     // ask the result side for one long hold-off
	bit  hold_done;
	int  hold_left;
	int  stall_left;
	int  gap_left;
	int  idle_cycles;
	sample_item_t next_item;
	report_t      want;
	bit           bad;

	// counters
	int n_items;
	int n_reports;
	int n_detours;
	int n_runs_ended;
	int n_errors;
	int n_mismatch;

	// ---- clock and reset --------------------------------------------------
	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		wr_en       = 1'b0;
		wr_index    = '0;
		wr_data     = '0;
		smp.valid     = 1'b0;
		smp.cmd       = dnr_pkg::CMD_BEGIN;
		smp.timestamp = '0;
		res.ready     = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic void clear_run_state();
		prev_t      = '0;
		win_t       = '0;
		detour_idx  = -WARMUP;
		rec_cnt     = '0;
		gap_hi      = '0;
		gap_lo      = dnr_pkg::GAP_MIN_RST;
		sample_cnt  = '0;
		first_rec_t = '0;
	endfunction

	// ---- prediction ---------------------------------------------------------
	// Advances the shadow run by one accepted item and queues the result item
	// that the core owes for it, if any.
	function automatic void predict_sample(input logic cmd, input logic [TS_W-1:0] now);
		logic [TS_W-1:0] gap;
		bit              hit;
		bit              done;
		report_t         r;
		hit = 1'b0;
		done = 1'b0;
		r = '{default: '0};
		if (cmd == dnr_pkg::CMD_BEGIN) begin
			// begin always restarts, even in the middle of a run
			clear_run_state();
			prev_t  = now;
			win_t   = now;
			running = 1'b1;
			return;
		end
		if (!running)
			return;    // sample while idle is dropped
		gap = now - prev_t;
		if (gap > thr_q) begin
			if (detour_idx >= 0) begin
				// first detour past warm-up restarts the timeout window
				if (detour_idx == 0) begin
					win_t       = prev_t;
					first_rec_t = prev_t;
				end
				hit             = 1'b1;
				r.detour_start  = prev_t;
				r.detour_length = gap;
				rec_cnt         = rec_cnt + 1'b1;
			end
			detour_idx++;
			if (detour_idx >= 0 && detour_idx >= int'(lim_q))
				done = 1'b1;
		end
		if (!done && (now - win_t) >= tmo_q)
			done = 1'b1;
		if (!done) begin
			// the ending sample leaves the stats untouched
			if (gap > gap_hi)
				gap_hi = gap;
			if (gap < gap_lo)
				gap_lo = gap;
			prev_t     = now;
			sample_cnt = sample_cnt + 1'b1;
			if (!hit)
				return;
		end
		r.has_detour     = hit;
		r.run_finished   = done;
		r.recorded_total = rec_cnt;
		if (done) begin
			r.smallest_gap  = gap_lo;
			r.largest_gap   = gap_hi;
			r.samples_taken = sample_cnt;
			r.elapsed_ticks = (rec_cnt != '0) ? (now - first_rec_t) : '0;
			running = 1'b0;
		end
		expected_reports.push_back(r);
	endfunction

	initial begin
		thr_q   = dnr_pkg::GAP_THRESHOLD_RST;
		tmo_q   = dnr_pkg::TIMEOUT_TICKS_RST;
		lim_q   = dnr_pkg::RECORD_LIMIT_RST;
		running = 1'b0;
		clear_run_state();
	end

	// ---- sample driver ------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			smp.valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (smp.valid && smp.ready) begin
				predict_sample(smp.cmd, smp.timestamp);
				n_items++;
			end
			// the slot is free when nothing is offered or the offer was taken
			if (!smp.valid || smp.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					smp.valid <= 1'b0;
				end else if (sample_backlog.size() > 0) begin
					next_item = sample_backlog.pop_front();
					smp.valid     <= 1'b1;
					smp.cmd       <= next_item.cmd;
					smp.timestamp <= next_item.timestamp;
					if (!calm && $urandom_range(0, 9) == 0)
						gap_left = $urandom_range(1, 11);
				end else begin
					smp.valid <= 1'b0;
				end
			end
		end
	end

	// ---- result monitor -----------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			hold_left  = 0;
			stall_left = 0;
		end else begin
			if (res.valid && res.ready) begin
				n_reports++;
				if (res.has_detour)
					n_detours++;
				if (res.run_finished)
					n_runs_ended++;
				if (expected_reports.size() == 0) begin
					n_errors++;
					if (n_mismatch < 10)
						$display("unexpected result item @%0t: det=%0b fin=%0b rec=%0d",
							$time, res.has_detour, res.run_finished, res.recorded_total);
					n_mismatch++;
				end else begin
					want = expected_reports.pop_front();
					bad = (res.has_detour !== want.has_detour)
						|| (res.detour_start !== want.detour_start)
						|| (res.detour_length !== want.detour_length)
						|| (res.run_finished !== want.run_finished)
						|| (res.recorded_total !== want.recorded_total)
						|| (res.smallest_gap !== want.smallest_gap)
						|| (res.largest_gap !== want.largest_gap)
						|| (res.samples_taken !== want.samples_taken)
						|| (res.elapsed_ticks !== want.elapsed_ticks);
					if (bad) begin
						n_errors++;
						if (n_mismatch < 10) begin
							$display("mismatch @%0t", $time);
							$display("  want det=%0b start=%h len=%h fin=%0b rec=%0d",
								want.has_detour, want.detour_start, want.detour_length,
								want.run_finished, want.recorded_total);
							$display("  got  det=%0b start=%h len=%h fin=%0b rec=%0d",
								res.has_detour, res.detour_start, res.detour_length,
								res.run_finished, res.recorded_total);
							$display("  want min=%h max=%h n=%h el=%h", want.smallest_gap,
								want.largest_gap, want.samples_taken, want.elapsed_ticks);
							$display("  got  min=%h max=%h n=%h el=%h", res.smallest_gap,
								res.largest_gap, res.samples_taken, res.elapsed_ticks);
						end
						n_mismatch++;
					end
				end
			end
			// ready: one long hold-off on request, else random stall bursts
			if (hold_go && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 11) - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// ---- watchdog -----------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((smp.valid && smp.ready) || (res.valid && res.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("watchdog: no handshake for %0d cycles, %0d results pending",
						idle_cycles, expected_reports.size());
					$display("tb: failure");
					$finish;
				end
			end
		end
	end

	// ---- sequencer ----------------------------------------------------------
	task automatic push_item(input logic cmd, input logic [TS_W-1:0] ts);
		sample_item_t it;
		it.cmd = cmd;
		it.timestamp = ts;
		sample_backlog.push_back(it);
	endtask

	// Waits until every item went in and every owed result came out, then
	// lets the pipe drain items that produce nothing.
	task automatic settle();
		do
			@(negedge clk);
		while (sample_backlog.size() != 0 || smp.valid || expected_reports.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input dnr_pkg::reg_idx_t idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		case (idx)
			dnr_pkg::REG_GAP_THRESHOLD: thr_q = data;
			dnr_pkg::REG_TIMEOUT_TICKS: tmo_q = data;
			dnr_pkg::REG_RECORD_LIMIT:  lim_q = data[REC_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [TS_W-1:0] thr, input logic [TS_W-1:0] tmo,
		input logic [REC_W-1:0] lim);
		write_reg(dnr_pkg::REG_GAP_THRESHOLD, thr);
		write_reg(dnr_pkg::REG_TIMEOUT_TICKS, tmo);
		write_reg(dnr_pkg::REG_RECORD_LIMIT, {{(CFG_W-REC_W){1'b0}}, lim});
		@(posedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Mostly well-formed runs (begin, then monotone timestamps whose gaps sit
	// around the threshold), mixed with stray begins and random samples.
	task automatic queue_runs(input int budget);
		int              left;
		int              len;
		int              k;
		int              pick;
		logic [TS_W-1:0] t;
		logic [TS_W-1:0] g;
		logic [TS_W-1:0] room;
		left = budget;
		room = ~thr_q;
		while (left > 0) begin
			if ($urandom_range(0, 99) < 15) begin
				push_item(1'($urandom_range(0, 1)), rand64());
				left--;
			end else begin
				// some runs start near the top so the counter wraps
				t = ($urandom_range(0, 7) == 0) ? (~64'd0 - 64'($urandom_range(0, 5000)))
					: rand64();
				push_item(dnr_pkg::CMD_BEGIN, t);
				left--;
				len = $urandom_range(15, 80);
				for (k = 0; k < len && left > 0; k++) begin
					pick = $urandom_range(0, 99);
					if (pick < 3)
						g = rand64();
					else if (pick < 30 && room != '0)
						g = thr_q + 1 + (64'($urandom_range(0, 3000)) % room);
					else if (pick < 35)
						g = thr_q;
					else if (thr_q == '1)
						g = rand64();
					else
						g = 64'($urandom) % (thr_q + 1);
					t = t + g;
					push_item(dnr_pkg::CMD_SAMPLE, t);
					left--;
				end
			end
		end
	endtask

	initial begin
		logic [TS_W-1:0]  t;
		logic [TS_W-1:0]  thr;
		logic [TS_W-1:0]  tmo;
		logic [REC_W-1:0] lim;
		int               p;
		calm = 1'b0;
		hold_go = 1'b0;
		hold_done = 1'b0;
		n_items = 0;
		n_reports = 0;
		n_detours = 0;
		n_runs_ended = 0;
		n_errors = 0;
		n_mismatch = 0;
		idle_cycles = 0;
		@(posedge arst_n);
		@(negedge clk);

		// -- directed: warm-up, window restart, wrap, limit end --------------
		set_config(64'd100, 64'd10000, 16'd2);
		push_item(dnr_pkg::CMD_SAMPLE, 64'd5);        // idle after reset: dropped
		t = ~64'd0 - 64'd600;
		push_item(dnr_pkg::CMD_BEGIN, t);
		push_item(dnr_pkg::CMD_SAMPLE, t + 64'd7);
		push_item(dnr_pkg::CMD_BEGIN, t);             // restart while running
		t = t + 64'd100;                     // gap equal to threshold: no detour
		push_item(dnr_pkg::CMD_SAMPLE, t);
		repeat (WARMUP) begin                // warm-up detours, crosses the wrap
			t = t + 64'd101;
			push_item(dnr_pkg::CMD_SAMPLE, t);
		end
		t = t + 64'd5000;                    // first recorded detour
		push_item(dnr_pkg::CMD_SAMPLE, t);
		t = t + 64'd1;
		push_item(dnr_pkg::CMD_SAMPLE, t);
		t = t + 64'd200;                     // second one hits the limit
		push_item(dnr_pkg::CMD_SAMPLE, t);
		push_item(dnr_pkg::CMD_SAMPLE, t + 64'd1);    // after the end: dropped
		settle();

		// -- directed: zero record limit ends on the last warm-up detour -----
		set_config(64'd0, ~64'd0, 16'd0);
		push_item(dnr_pkg::CMD_BEGIN, 64'd0);
		for (int i = 1; i <= WARMUP; i++)
			push_item(dnr_pkg::CMD_SAMPLE, 64'(i));
		settle();

		// -- random phases ----------------------------------------------------
		for (p = 0; p < N_PHASES; p++) begin
			case (p)
				0: begin
					thr = 64'($urandom_range(50, 2000));
					tmo = thr * 64'($urandom_range(20, 80));
					lim = 16'($urandom_range(1, 20));
				end
				1: begin
					thr = '0;
					tmo = 64'($urandom_range(200, 20000));
					lim = 16'($urandom_range(1, 30));
				end
				2: begin
					// zero timeout: every run ends on its first sample
					thr = '1;
					tmo = '0;
					lim = 16'hFFFF;
				end
				3: begin
					thr = 64'($urandom_range(100, 1000));
					tmo = '1;
					lim = 16'hFFFF;
					hold_go = 1'b1;   // back the core up during this phase
				end
				4: begin
					thr = rand64();
					tmo = rand64();
					lim = 16'($urandom_range(1, 65535));
				end
				5: begin
					thr = 64'($urandom_range(1, 500));
					tmo = 64'($urandom_range(1000, 50000));
					lim = 16'($urandom_range(1, 8));
				end
				default: begin
					calm = 1'b1;
					thr = 64'($urandom_range(50, 2000));
					tmo = thr * 64'd30;
					lim = 16'($urandom_range(2, 12));
				end
			endcase
			set_config(thr, tmo, lim);
			queue_runs(PHASE_ITEMS);
			settle();
		end

		$display("run: %0d items in, %0d results out, %0d detours reported, %0d runs closed",
			n_items, n_reports, n_detours, n_runs_ended);
		$display("run: thresholds 0..max, timeouts 0..max, record limits 0..65535");
		if (n_errors == 0 && expected_reports.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("errors: %0d, results still owed: %0d", n_errors,
				expected_reports.size());
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> files.f
src/dnr_pkg.sv
src/dnr_if.sv
src/detour_noise_recorder_core.sv
sim/detour_noise_recorder_core_tb.sv
